// ----- rtl/pba_pkg.sv -----
package pba_pkg;

  localparam int MAX_PAGES    = 64;
  localparam int MAX_BLOCKS   = 4096;
  localparam int HEADER_BYTES = 8;
  localparam int CNT_MAX      = 8191;

  // stack index and depth (depth can reach MAX_BLOCKS itself)
  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int DEPTH_W = IDX_W + 1;

  // block size in bytes: up to 8191 rounded to 2^15
  localparam int BB_W  = 16;
  // blocks per page: (page length - header) / block size
  localparam int BPP_W = 17;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_FREE_ALL = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_POOL_EXHAUSTED = 2'd1,
    ST_PAGE_TOO_SMALL = 2'd2,
    ST_STACK_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_PAYLOAD_LEN = 2'd0,
    CFG_PAGE_LEN    = 2'd1,
    CFG_ALIGN_LOG2  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] block_address;
  } in_word_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [1:0]  status;
    logic [6:0]  page_count;
    logic [12:0] total_blocks;
    logic [12:0] free_blocks;
  } out_word_t;

  // max(payload, header) rounded up to 2^align
  function automatic logic [BB_W-1:0] block_bytes(input logic [12:0] payload_len,
                                                  input logic [3:0]  align_log2);
    logic [BB_W-1:0] need;
    logic [BB_W-1:0] mask;
    need = (payload_len < 13'(HEADER_BYTES)) ? BB_W'(HEADER_BYTES) : BB_W'(payload_len);
    mask = (BB_W'(1) << align_log2) - BB_W'(1);
    return (need + mask) & ~mask;
  endfunction

endpackage

// ----- rtl/pba_ram.sv -----
module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/paged_block_allocator.sv -----
// Throughput: one word per cycle, unless the divider is busy or the output stalls.
// A word waits in the work stage, its result in the output register. The stack RAM
// has a registered read, issued at accept. After reset and each mapped config write, a
// restoring divide computes blocks per page, with in_ready low and cfg_ready high.
// Reset: synchronous, active low; clears counters, pointers and handshake state;
// the free stack RAM is not cleared (entries are only used below the stack depth).
module paged_block_allocator (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  pba_pkg::in_word_t   in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output pba_pkg::out_word_t  out_data,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [16:0]         cfg_data
);

  import pba_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [12:0] payload_len_r;
  logic [16:0] page_len_r;
  logic [3:0]  align_log2_r;
  logic        cfg_hit;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == CFG_PAYLOAD_LEN ||
                                   cfg_index == CFG_PAGE_LEN ||
                                   cfg_index == CFG_ALIGN_LOG2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_len_r <= 13'd16;
      page_len_r    <= 17'd4096;
      align_log2_r  <= 4'd3;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PAYLOAD_LEN: payload_len_r <= cfg_data[12:0];
        CFG_PAGE_LEN:    page_len_r    <= cfg_data;
        CFG_ALIGN_LOG2:  align_log2_r  <= cfg_data[3:0];
        default: ;  // unmapped index: no effect
      endcase
    end
  end

  logic [BB_W-1:0] blk_bytes;
  assign blk_bytes = block_bytes(payload_len_r, align_log2_r);

  // ---------------------------------------------------------------------------
  // Blocks-per-page divider: restoring, one quotient bit per cycle.
  // quo_r starts as the dividend and shifts quotient bits in from the bottom.
  // ---------------------------------------------------------------------------
  logic             div_load_r;
  logic [4:0]       div_cnt_r;
  logic [BB_W-1:0]  div_rem_r;
  logic [BPP_W-1:0] div_quo_r;
  logic             div_busy;
  logic [BPP_W-1:0] dividend;
  logic [BB_W:0]    rem_shift;
  logic             rem_ge;
  logic [BPP_W-1:0] bpp;

  assign div_busy  = div_load_r || (div_cnt_r != 5'd0);
  assign dividend  = (page_len_r > 17'(HEADER_BYTES)) ?
                     (page_len_r - 17'(HEADER_BYTES)) : '0;
  assign rem_shift = {div_rem_r, div_quo_r[BPP_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, blk_bytes};
  assign bpp       = div_quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_load_r <= 1'b1;
      div_cnt_r  <= '0;
    end else if (cfg_hit) begin
      // config registers settle at this edge; divide on the new values
      div_load_r <= 1'b1;
      div_cnt_r  <= '0;
    end else if (div_load_r) begin
      div_load_r <= 1'b0;
      div_cnt_r  <= 5'(BPP_W);
    end else if (div_cnt_r != 5'd0) begin
      div_cnt_r <= div_cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_load_r) begin
      div_rem_r <= '0;
      div_quo_r <= dividend;
    end else if (div_cnt_r != 5'd0) begin
      div_rem_r <= rem_ge ? BB_W'(rem_shift - {1'b0, blk_bytes}) : rem_shift[BB_W-1:0];
      div_quo_r <= {div_quo_r[BPP_W-2:0], rem_ge};
    end
  end

  // ---------------------------------------------------------------------------
  // Pool state
  // ---------------------------------------------------------------------------
  logic [DEPTH_W-1:0] depth_r,      depth_nxt;
  logic [6:0]         pages_r,      pages_nxt;
  logic [31:0]        carve_addr_r, carve_addr_nxt;
  logic [12:0]        carve_left_r, carve_left_nxt;
  logic [12:0]        total_r,      total_nxt;
  logic [12:0]        free_r,       free_nxt;
  logic [31:0]        page_base_r,  page_base_nxt;  // pages_r * page length, running

  // work stage: one accepted word whose stack read is in flight or whose
  // result waits for the output register
  logic       work_valid_r;
  in_word_t   work_r;
  logic       fwd_r;        // popped entry is the one pushed in the accept cycle
  logic [31:0] fwd_data_r;

  logic       out_valid_r;
  out_word_t  out_data_r;

  logic       complete;
  logic       accept;
  logic       push_en;
  out_word_t  result;

  // stack RAM
  logic [31:0]        ram_rdata;
  logic [31:0]        pop_data;
  logic [DEPTH_W-1:0] depth_eff;
  logic [IDX_W-1:0]   rd_idx;

  assign complete = work_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !div_busy && (!work_valid_r || complete);
  assign accept   = in_valid && in_ready;

  // depth seen by the accepted word: includes the word retiring this cycle
  assign depth_eff = complete ? depth_nxt : depth_r;
  assign rd_idx    = IDX_W'(depth_eff - DEPTH_W'(1));
  assign pop_data  = fwd_r ? fwd_data_r : ram_rdata;

  pba_ram #(
    .WIDTH (32),
    .DEPTH (MAX_BLOCKS)
  ) u_stack (
    .clk   (clk),
    .we    (push_en),
    .waddr (depth_r[IDX_W-1:0]),
    .wdata (work_r.block_address),
    .re    (accept),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // Retire logic for the word in the work stage
  always_comb begin
    logic [17:0]      free_sum;
    logic [BPP_W-1:0] room;
    depth_nxt      = depth_r;
    pages_nxt      = pages_r;
    carve_addr_nxt = carve_addr_r;
    carve_left_nxt = carve_left_r;
    total_nxt      = total_r;
    free_nxt       = free_r;
    page_base_nxt  = page_base_r;
    push_en        = 1'b0;
    free_sum       = 18'(free_r) + 18'(bpp) - 18'd1;
    room           = BPP_W'(MAX_BLOCKS) - BPP_W'(total_r);
    result                 = '0;
    result.status          = ST_OK;

    if (complete) begin
      unique case (opcode_t'(work_r.opcode))
        OP_ALLOC: begin
          if (depth_r != '0) begin
            // most recently freed block first
            depth_nxt              = depth_r - DEPTH_W'(1);
            result.granted_address = pop_data;
            if (free_r != '0) free_nxt = free_r - 13'd1;
          end else if (carve_left_r != '0) begin
            result.granted_address = carve_addr_r;
            carve_addr_nxt         = carve_addr_r + 32'(blk_bytes);
            carve_left_nxt         = carve_left_r - 13'd1;
            if (free_r != '0) free_nxt = free_r - 13'd1;
          end else if (bpp == '0) begin
            result.status = ST_PAGE_TOO_SMALL;
          end else if (pages_r >= 7'(MAX_PAGES) || bpp > room) begin
            result.status = ST_POOL_EXHAUSTED;
          end else begin
            // open a new page, hand out its first block
            result.granted_address = page_base_r + 32'(HEADER_BYTES);
            carve_addr_nxt = page_base_r + 32'(HEADER_BYTES) + 32'(blk_bytes);
            carve_left_nxt = 13'(bpp - BPP_W'(1));
            pages_nxt      = pages_r + 7'd1;
            page_base_nxt  = page_base_r + 32'(page_len_r);
            total_nxt      = 13'(BPP_W'(total_r) + bpp);
            free_nxt       = (free_sum > 18'(CNT_MAX)) ? 13'(CNT_MAX) : free_sum[12:0];
          end
        end
        OP_FREE: begin
          if (depth_r >= DEPTH_W'(MAX_BLOCKS)) begin
            result.status = ST_STACK_FULL;
          end else begin
            push_en   = 1'b1;
            depth_nxt = depth_r + DEPTH_W'(1);
            if (free_r != 13'(CNT_MAX)) free_nxt = free_r + 13'd1;
          end
        end
        OP_FREE_ALL: begin
          depth_nxt      = '0;
          pages_nxt      = '0;
          carve_addr_nxt = '0;
          carve_left_nxt = '0;
          total_nxt      = '0;
          free_nxt       = '0;
          page_base_nxt  = '0;
        end
        default: ;  // unused opcode: no state change, status ok
      endcase
    end

    result.page_count   = pages_nxt;
    result.total_blocks = total_nxt;
    result.free_blocks  = free_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      // any write to a mapped register also frees everything
      depth_r      <= '0;
      pages_r      <= '0;
      carve_addr_r <= '0;
      carve_left_r <= '0;
      total_r      <= '0;
      free_r       <= '0;
      page_base_r  <= '0;
    end else begin
      depth_r      <= depth_nxt;
      pages_r      <= pages_nxt;
      carve_addr_r <= carve_addr_nxt;
      carve_left_r <= carve_left_nxt;
      total_r      <= total_nxt;
      free_r       <= free_nxt;
      page_base_r  <= page_base_nxt;
    end
  end

  // work stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        work_valid_r <= 1'b1;
      end else if (complete) begin
        work_valid_r <= 1'b0;
      end
      if (complete) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work_r     <= in_data;
      // a push retiring now writes the very entry this word would pop
      fwd_r      <= push_en;
      fwd_data_r <= work_r.block_address;
    end
    if (complete) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(MAX_BLOCKS))
    else $error("free stack depth beyond capacity");

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= 13'(MAX_BLOCKS) && pages_r <= 7'(MAX_PAGES))
    else $error("pool counters beyond limits");

  a_no_accept_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !div_busy)
    else $error("request taken while blocks per page is stale");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(work_valid_r))
    else $error("result word without a pending request");
`endif

endmodule

// ----- test/testbench.sv -----
module testbench;
  import pba_pkg::*;

  // codes the package leaves unnamed: spare opcode and spare register index
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_WORDS = 1560;
  localparam int unsigned IDLE_PCT     = 35;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 100;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  always #1 clk = ~clk;

  paged_block_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Pool mirror: configuration, free stack, carve pointer and counters,
  // all as the block should hold them after each accepted word.
  // ---------------------------------------------------------------------------
  logic [12:0] cur_data  = 13'd16;
  logic [16:0] cur_page  = 17'd4096;
  logic [3:0]  cur_align = 4'd3;

  logic [31:0] stack_mem [MAX_BLOCKS];
  int unsigned stack_depth = 0;
  int unsigned pages_used  = 0;
  logic [31:0] carve_ptr   = '0;
  int unsigned carve_rem   = 0;
  int unsigned total_blk   = 0;
  int unsigned free_blk    = 0;

  // addresses handed out and not yet returned; feeds well-formed frees
  logic [31:0] live_blocks[$];

  // replies the block owes, oldest first
  out_word_t due_replies[$];

  bit          steady = 1'b0;   // no idling on either side while set
  int unsigned mismatches = 0;
  int unsigned replies_seen = 0;
  int unsigned words_sent = 0;
  int unsigned cycles = 0;

  function automatic void empty_pool();
    stack_depth = 0;
    pages_used  = 0;
    carve_ptr   = '0;
    carve_rem   = 0;
    total_blk   = 0;
    free_blk    = 0;
    live_blocks.delete();
  endfunction

  // max(data, header) rounded up to 2^align
  function automatic int unsigned blk_size();
    int unsigned need;
    int unsigned step;
    need = (cur_data < HEADER_BYTES) ? HEADER_BYTES : cur_data;
    step = 32'd1 << cur_align;
    return (need + step - 1) & ~(step - 1);
  endfunction

  function automatic int unsigned blks_per_page();
    if (cur_page <= HEADER_BYTES) return 0;
    return (cur_page - HEADER_BYTES) / blk_size();
  endfunction

  // Reply for one request word; advances the mirror.
  function automatic out_word_t pool_service(in_word_t w);
    out_word_t   r;
    int unsigned per_page;
    r = '0;
    case (w.opcode)
      OP_ALLOC: begin
        if (stack_depth > 0) begin
          // most recently freed address goes out first
          stack_depth--;
          r.granted_address = stack_mem[stack_depth];
          if (free_blk > 0) free_blk--;
        end else if (carve_rem > 0) begin
          r.granted_address = carve_ptr;
          carve_ptr = carve_ptr + blk_size();
          carve_rem--;
          if (free_blk > 0) free_blk--;
        end else begin
          per_page = blks_per_page();
          if (per_page == 0) begin
            r.status = ST_PAGE_TOO_SMALL;
          end else if (pages_used >= MAX_PAGES || per_page > MAX_BLOCKS - total_blk) begin
            r.status = ST_POOL_EXHAUSTED;
          end else begin
            // new page: first block right past the page header
            r.granted_address = pages_used * cur_page + HEADER_BYTES;
            carve_ptr = r.granted_address + blk_size();
            carve_rem = per_page - 1;
            pages_used++;
            total_blk += per_page;
            free_blk  += per_page - 1;
            if (free_blk > CNT_MAX) free_blk = CNT_MAX;
          end
        end
      end
      OP_FREE: begin
        if (stack_depth >= MAX_BLOCKS) begin
          r.status = ST_STACK_FULL;
        end else begin
          // no check on the address: foreign and duplicate frees are stacked too
          stack_mem[stack_depth] = w.block_address;
          stack_depth++;
          if (free_blk < CNT_MAX) free_blk++;
        end
      end
      OP_FREE_ALL: empty_pool();
      default: ;
    endcase
    r.page_count   = 7'(pages_used);
    r.total_blocks = 13'(total_blk);
    r.free_blocks  = 13'(free_blk);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Reply checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MAX_REPORTS)
      $display("reply %0d: %s is %0h, expected %0h", replies_seen, what, got, want);
    mismatches++;
  endtask

  // out_ready: low about IDLE_PCT percent of the time, never while steady
  always @(posedge clk) out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) cycles <= cycles + 1;

  always @(posedge clk) begin : reply_check
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      replies_seen++;
      if (due_replies.size() == 0) begin
        report_mismatch("reply with none due, address", out_data.granted_address, '0);
      end else begin
        want = due_replies.pop_front();
        if (out_data.granted_address !== want.granted_address)
          report_mismatch("granted_address", out_data.granted_address,
                          want.granted_address);
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.page_count !== want.page_count)
          report_mismatch("page_count", 32'(out_data.page_count), 32'(want.page_count));
        if (out_data.total_blocks !== want.total_blocks)
          report_mismatch("total_blocks", 32'(out_data.total_blocks),
                          32'(want.total_blocks));
        if (out_data.free_blocks !== want.free_blocks)
          report_mismatch("free_blocks", 32'(out_data.free_blocks),
                          32'(want.free_blocks));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. All inputs change by nonblocking assignment right after a rising
  // edge; a handshake is read right after the edge, i.e. the pre-edge values.
  // ---------------------------------------------------------------------------

  // One request word. The reply pushed is either the fixed one from the
  // directed table or the mirror's; the mirror is advanced in both cases.
  task automatic send_req(input in_word_t w, input bit typed, input out_word_t fixed,
                          output out_word_t pred);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    pred = pool_service(w);
    due_replies.push_back(typed ? fixed : pred);
    words_sent++;
    // in_valid is left high: the next word either reuses it or drops it
  endtask

  task automatic burst(input logic [1:0] op, input int unsigned n);
    in_word_t  w;
    out_word_t seen;
    repeat (n) begin
      w.opcode = op;
      w.block_address = $urandom();
      send_req(w, 1'b0, '0, seen);
    end
  endtask

  // wait until every reply owed has come back
  task automatic await_replies();
    if (due_replies.size() != 0) begin
      in_valid <= 1'b0;
      while (due_replies.size() != 0) @(posedge clk);
    end
  endtask

  // Register write, only with the block idle. Any real register write clears
  // the pool; the spare index changes nothing.
  task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
    await_replies();
    // a lowering of cfg_valid still pending in this step: let it land first
    if (cfg_valid) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PAYLOAD_LEN: cur_data  = val[12:0];
      CFG_PAGE_LEN:    cur_page  = val;
      CFG_ALIGN_LOG2:  cur_align = val[3:0];
      default: ;
    endcase
    if (idx != CFG_UNUSED) empty_pool();
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  code;    // opcode or register index
    logic [31:0] value;   // address or register data
    bit          typed;   // reply fixed in the table
    out_word_t   want;
  } dir_row_t;

  function automatic dir_row_t cfg_row(logic [1:0] idx, logic [16:0] val);
    dir_row_t r;
    r.kind  = ROW_CFG;
    r.code  = idx;
    r.value = 32'(val);
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic dir_row_t req_row(logic [1:0] op, logic [31:0] addr);
    dir_row_t r;
    r.kind  = ROW_REQ;
    r.code  = op;
    r.value = addr;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic dir_row_t chk_row(logic [1:0] op, logic [31:0] addr, logic [31:0] g,
                                       status_t st, int unsigned pc, int unsigned tot,
                                       int unsigned fr);
    dir_row_t r;
    r = req_row(op, addr);
    r.typed = 1'b1;
    r.want.granted_address = g;
    r.want.status          = st;
    r.want.page_count      = 7'(pc);
    r.want.total_blocks    = 13'(tot);
    r.want.free_blocks     = 13'(fr);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t    rows[$];
    in_word_t    w;
    out_word_t   seen;
    int unsigned n_rand;
    int unsigned phase;
    int unsigned plen;
    int unsigned alloc_pct;
    int unsigned pick;
    int unsigned k;
    int unsigned v;

    // after reset: 16-byte blocks, 4096-byte pages -> 255 blocks per page
    rows.push_back(chk_row(OP_ALLOC, 32'h0, 32'd8, ST_OK, 1, 255, 254));
    rows.push_back(chk_row(OP_ALLOC, 32'hFFFF_FFFF, 32'd24, ST_OK, 1, 255, 253));
    // foreign address is stacked and handed straight back
    rows.push_back(chk_row(OP_FREE, 32'hFFFF_FFFF, 32'd0, ST_OK, 1, 255, 254));
    rows.push_back(chk_row(OP_ALLOC, 32'h0, 32'hFFFF_FFFF, ST_OK, 1, 255, 253));
    rows.push_back(chk_row(OP_FREE, 32'h0, 32'd0, ST_OK, 1, 255, 254));
    rows.push_back(chk_row(OP_UNUSED, 32'hA5A5_A5A5, 32'd0, ST_OK, 1, 255, 254));
    rows.push_back(req_row(OP_ALLOC, 32'h5A5A_5A5A));
    rows.push_back(chk_row(OP_FREE_ALL, 32'h5A5A_5A5A, 32'd0, ST_OK, 0, 0, 0));
    rows.push_back(chk_row(OP_ALLOC, 32'h0, 32'd8, ST_OK, 1, 255, 254));
    rows.push_back(req_row(OP_FREE, 32'd8));
    rows.push_back(req_row(OP_ALLOC, 32'h0));
    // page no bigger than its header, then a page with room for no block
    rows.push_back(cfg_row(CFG_PAGE_LEN, 17'd8));
    rows.push_back(chk_row(OP_ALLOC, 32'h0, 32'd0, ST_PAGE_TOO_SMALL, 0, 0, 0));
    rows.push_back(cfg_row(CFG_PAGE_LEN, 17'd16));
    rows.push_back(chk_row(OP_ALLOC, 32'h0, 32'd0, ST_PAGE_TOO_SMALL, 0, 0, 0));
    // one 8-byte block per 16-byte page
    rows.push_back(cfg_row(CFG_PAYLOAD_LEN, 17'd1));
    rows.push_back(chk_row(OP_ALLOC, 32'h0, 32'd8, ST_OK, 1, 1, 0));
    rows.push_back(chk_row(OP_ALLOC, 32'h0, 32'd24, ST_OK, 2, 2, 0));
    // one page would exceed the whole block budget
    rows.push_back(cfg_row(CFG_PAGE_LEN, 17'd65536));
    rows.push_back(chk_row(OP_ALLOC, 32'h0, 32'd0, ST_POOL_EXHAUSTED, 0, 0, 0));
    // widest alignment: one 32 KiB block per page
    rows.push_back(cfg_row(CFG_ALIGN_LOG2, 17'd15));
    rows.push_back(chk_row(OP_ALLOC, 32'h0, 32'd8, ST_OK, 1, 1, 0));
    rows.push_back(chk_row(OP_ALLOC, 32'h0, 32'd65544, ST_OK, 2, 2, 0));
    // largest data size, upper data bits set; align field masked down to zero
    rows.push_back(cfg_row(CFG_PAYLOAD_LEN, 17'h1FFFF));
    rows.push_back(cfg_row(CFG_ALIGN_LOG2, 17'h1FFF0));
    rows.push_back(chk_row(OP_ALLOC, 32'h0, 32'd8, ST_OK, 1, 8, 7));
    rows.push_back(chk_row(OP_ALLOC, 32'h0, 32'd8199, ST_OK, 1, 8, 6));
    rows.push_back(cfg_row(CFG_PAGE_LEN, 17'h1FFFF));
    rows.push_back(chk_row(OP_ALLOC, 32'h0, 32'd8, ST_OK, 1, 16, 15));
    // spare register index leaves the pool alone
    rows.push_back(cfg_row(CFG_UNUSED, 17'h15555));
    rows.push_back(chk_row(OP_ALLOC, 32'h0, 32'd8199, ST_OK, 1, 16, 14));
    // zero data size falls back to the header size
    rows.push_back(cfg_row(CFG_PAYLOAD_LEN, 17'd0));
    rows.push_back(chk_row(OP_ALLOC, 32'h0, 32'd0, ST_POOL_EXHAUSTED, 0, 0, 0));

    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        write_reg(rows[i].code, rows[i].value[16:0]);
      end else begin
        w.opcode        = rows[i].code;
        w.block_address = rows[i].value;
        send_req(w, rows[i].typed, rows[i].want, seen);
      end
    end

    // page count limit: one block per page, the word after the last page fails
    write_reg(CFG_PAYLOAD_LEN, 17'd8);
    write_reg(CFG_ALIGN_LOG2, 17'd3);
    write_reg(CFG_PAGE_LEN, 17'd16);
    burst(OP_ALLOC, MAX_PAGES + 1);

    // Random part: a fresh setting per phase, then mostly allocates and frees
    // of live blocks, with stray frees, spare opcodes and free-alls mixed in.
    n_rand = 0;
    phase  = 0;
    while (n_rand < RANDOM_WORDS) begin
      steady = (phase == 4 || phase == 5);

      case ($urandom_range(9))
        0: v = 0;
        1: v = 8191;
        2: v = $urandom_range(8191);
        default: v = $urandom_range(1, 40);
      endcase
      write_reg(CFG_PAYLOAD_LEN, {4'($urandom_range(15)), 13'(v)});

      case ($urandom_range(9))
        0: v = $urandom_range(16);
        1: v = 17'h1FFFF;
        2: v = $urandom_range(17'h1FFFF);
        3: v = 65536;
        default: v = $urandom_range(16, 400);
      endcase
      write_reg(CFG_PAGE_LEN, 17'(v));

      case ($urandom_range(9))
        0: v = 15;
        1: v = $urandom_range(15);
        default: v = $urandom_range(4);
      endcase
      write_reg(CFG_ALIGN_LOG2, {13'($urandom_range(8191)), 4'(v)});

      if ($urandom_range(9) == 0) write_reg(CFG_UNUSED, 17'($urandom()));

      plen      = $urandom_range(20, 120);
      alloc_pct = $urandom_range(35, 85);
      repeat (plen) begin
        pick = $urandom_range(99);
        w.block_address = $urandom();
        if (pick < alloc_pct) begin
          w.opcode = OP_ALLOC;
        end else if (pick < 93) begin
          w.opcode = OP_FREE;
          if (live_blocks.size() != 0) begin
            k = $urandom_range(live_blocks.size() - 1);
            w.block_address = live_blocks[k];
            live_blocks.delete(k);
          end
        end else if (pick < 96) begin
          w.opcode = OP_FREE;
        end else if (pick < 98) begin
          w.opcode = OP_UNUSED;
        end else begin
          w.opcode = OP_FREE_ALL;
        end
        send_req(w, 1'b0, '0, seen);
        if (w.opcode == OP_ALLOC && seen.status == ST_OK)
          live_blocks.push_back(seen.granted_address);
        if (w.opcode != OP_UNUSED) n_rand++;
      end
      phase++;
    end
    steady = 1'b0;

    await_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d request words (%0d random over %0d settings), checked %0d replies.",
             words_sent, n_rand, phase, replies_seen);
    $display("Covered page limit, oversized and tiny pages, stray frees; %0d cycles.",
             cycles);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
